/* src/ordered_keyed_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// ordered_keyed_list_engine_defines
// Assertion macros shared by the ordered keyed list engine.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEYED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_KEYED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OKLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define OKLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// delayed implication, disabled in reset
`define OKLE_ASSERT_LATER3(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) else $error(msg);

`endif

/* src/okle_pkg.sv */
// ----------------------------------------------------------------------------
// okle_pkg
// Types and codes shared by the ordered keyed list engine.
// ----------------------------------------------------------------------------
package okle_pkg;

   // widest title the payload can carry
   localparam int MAX_TITLE_BYTES = 20;
   localparam int RAW_TITLE_W     = MAX_TITLE_BYTES * 8;
   localparam int COUNT_OUT_W     = 5;

   // operation codes; the unused code acts as a lookup
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // result status codes
   localparam logic [2:0] STS_INSERTED  = 3'd0;
   localparam logic [2:0] STS_DUPLICATE = 3'd1;
   localparam logic [2:0] STS_FULL      = 3'd2;
   localparam logic [2:0] STS_DELETED   = 3'd3;
   localparam logic [2:0] STS_NOT_FOUND = 3'd4;
   localparam logic [2:0] STS_HIT       = 3'd5;
   localparam logic [2:0] STS_MISS      = 3'd6;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] title_bytes_0_7;
      logic [63:0] title_bytes_8_15;
      logic [31:0] title_bytes_16_19;
      logic        media_kind;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic                   found_kind;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_hold;
   } dp_stat_type;

endpackage

/* src/okle_ctrl.sv */
// ----------------------------------------------------------------------------
// okle_ctrl
// Sequencer: capture a beat, compare against all entries, then commit.
// ----------------------------------------------------------------------------
module okle_ctrl
   import okle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type dp_stat,
   output cmd_type     cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // wait for the output register to free up
            if (!dp_stat.rsp_hold) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
         end
         ST_UPDATE: begin
            cmd.commit = !dp_stat.rsp_hold;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* src/okle_dp.sv */
// ----------------------------------------------------------------------------
// okle_dp
// Entry storage, per-entry match cells, first-match logic and result register.
// ----------------------------------------------------------------------------
module okle_dp
   import okle_pkg::*;
#(
   parameter int LIST_DEPTH  = 16,
   parameter int TITLE_BYTES = 20
)
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  cmd_type     cmd,
   output dp_stat_type dp_stat,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int TW = TITLE_BYTES * 8;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int LV = $clog2(LIST_DEPTH);

   // captured request
   logic [1:0]    op_ff;
   logic [TW-1:0] title_ff;
   logic          kind_ff;
   logic [TW-1:0] title_norm;
   logic [RAW_TITLE_W-1:0] raw_title;

   // entry storage and count
   logic [TW-1:0]         entry_title_ff [LIST_DEPTH];
   logic [TW-1:0]         entry_title_in [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] entry_kind_ff;
   logic [LIST_DEPTH-1:0] entry_kind_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;

   // match vectors
   logic [LIST_DEPTH-1:0] title_eq;
   logic [LIST_DEPTH-1:0] full_eq;
   logic [LIST_DEPTH-1:0] match_title_ff;
   logic [LIST_DEPTH-1:0] match_full_ff;
   logic [LIST_DEPTH-1:0] pre_title [LV+1];
   logic [LIST_DEPTH-1:0] pre_full [LV+1];
   logic [LIST_DEPTH-1:0] first_title;
   logic [LIST_DEPTH-1:0] del_region;

   // decode
   logic any_full;
   logic any_title;
   logic is_full;
   logic do_insert;
   logic do_delete;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // title unpack: zero everything after the first zero character
   assign raw_title = {req_data.title_bytes_16_19, req_data.title_bytes_8_15,
                       req_data.title_bytes_0_7};

   always_comb begin
      logic alive;
      title_norm = '0;
      for (int i = 0; i < TITLE_BYTES; i++) begin
         alive = 1'b1;
         for (int j = 0; j < i; j++) begin
            alive = alive & (raw_title[8*j +: 8] != 8'h00);
         end
         title_norm[8*i +: 8] = alive ? raw_title[8*i +: 8] : 8'h00;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.operation;
         title_ff <= title_norm;
         kind_ff  <= req_data.media_kind;
      end
   end

   // per-entry compare, live entries only
   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         title_eq[i] = (entry_title_ff[i] == title_ff) && (CW'(i) < count_ff);
         full_eq[i]  = title_eq[i] && (entry_kind_ff[i] == kind_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_title_ff <= title_eq;
         match_full_ff  <= full_eq;
      end
   end

   // log-depth prefix OR: marks each match and everything after it
   always_comb begin
      pre_title[0] = match_title_ff;
      pre_full[0]  = match_full_ff;
      for (int l = 0; l < LV; l++) begin
         for (int i = 0; i < LIST_DEPTH; i++) begin
            if (i >= (1 << l)) begin
               pre_title[l+1][i] = pre_title[l][i] | pre_title[l][i - (1 << l)];
               pre_full[l+1][i]  = pre_full[l][i] | pre_full[l][i - (1 << l)];
            end else begin
               pre_title[l+1][i] = pre_title[l][i];
               pre_full[l+1][i]  = pre_full[l][i];
            end
         end
      end
      first_title = match_title_ff & ~(pre_title[LV] << 1);
      del_region  = pre_full[LV];
   end

   // operation decode and result
   assign any_full  = |match_full_ff;
   assign any_title = |match_title_ff;
   assign is_full   = (count_ff == CW'(LIST_DEPTH));

   always_comb begin
      do_insert = 1'b0;
      do_delete = 1'b0;
      count_in  = count_ff;
      rsp_in    = '0;
      unique case (op_ff)
         OP_INSERT: begin
            if (any_full) begin
               rsp_in.status = STS_DUPLICATE;
            end else if (is_full) begin
               rsp_in.status = STS_FULL;
            end else begin
               rsp_in.status = STS_INSERTED;
               do_insert     = cmd.commit;
               count_in      = CW'(count_ff + 1'b1);
            end
         end
         OP_DELETE: begin
            if (any_full) begin
               rsp_in.status = STS_DELETED;
               do_delete     = cmd.commit;
               count_in      = CW'(count_ff - 1'b1);
            end else begin
               rsp_in.status = STS_NOT_FOUND;
            end
         end
         default: begin
            rsp_in.status     = any_title ? STS_HIT : STS_MISS;
            rsp_in.found_kind = |(first_title & entry_kind_ff);
         end
      endcase
      rsp_in.entry_count = COUNT_OUT_W'(count_in);
   end

   // entry cells: shift down on insert, close the gap on delete
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      always_comb begin
         entry_title_in[i] = entry_title_ff[i];
         entry_kind_in[i]  = entry_kind_ff[i];
         if (do_insert) begin
            if (i == 0) begin
               entry_title_in[i] = title_ff;
               entry_kind_in[i]  = kind_ff;
            end else begin
               entry_title_in[i] = entry_title_ff[(i == 0) ? 0 : i - 1];
               entry_kind_in[i]  = entry_kind_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (do_delete && del_region[i] && (i < LIST_DEPTH - 1)) begin
            entry_title_in[i] = entry_title_ff[(i < LIST_DEPTH - 1) ? i + 1 : i];
            entry_kind_in[i]  = entry_kind_ff[(i < LIST_DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_title_ff <= entry_title_in;
      entry_kind_ff  <= entry_kind_in;
   end

   // count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign dp_stat.rsp_hold = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

endmodule

/* src/ordered_keyed_list_engine.sv */
// Flow: each accepted request is captured, compared in parallel and then committed;
//   the response beat is registered at commit, and no new request is taken until idle;
//   commit waits while an earlier response is still held at the output.
// Reset: clears the entry count, the sequencer and the response valid; the entry
//   storage is not cleared, only entries below the count are ever compared.
// ----------------------------------------------------------------------------
// ordered_keyed_list_engine
// Ordered list of titled entries with insert at head, delete and lookup.
// ----------------------------------------------------------------------------
`include "ordered_keyed_list_engine_defines.svh"

module ordered_keyed_list_engine
   import okle_pkg::*;
#(
   parameter int LIST_DEPTH  = 16,
   parameter int TITLE_BYTES = 20
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type     cmd;
   dp_stat_type dp_stat;

   // sequencer
   okle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   // storage and match datapath
   okle_dp #(
      .LIST_DEPTH  (LIST_DEPTH),
      .TITLE_BYTES (TITLE_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_stat   (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // checks
   `OKLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")
   `OKLE_ASSERT_LATER3(a_rsp_after_accept, clock, reset, req_valid && req_ready, rsp_valid, "no response after accept")
   `OKLE_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && (rsp_data.status == STS_FULL), rsp_data.entry_count == COUNT_OUT_W'(LIST_DEPTH), "full drop with list not full")
   `OKLE_ASSERT_NOW(a_kind_on_hit, clock, reset, rsp_valid && rsp_data.found_kind, rsp_data.status == STS_HIT, "found kind set without lookup hit")

endmodule
